[rtl/core/lccs_pkg.sv]
// Shared constants, types and helper functions for the lattice Cantor code step unit.
package lccs_pkg;

  // Representable coordinates have a zigzag value below 2^CoordBits
  localparam int unsigned CoordBits = 16;
  localparam logic [31:0] ZzLimit   = 32'(1) << CoordBits;

  // Field and datapath widths
  localparam int unsigned CmdW   = 2;
  localparam int unsigned DirW   = 2;
  localparam int unsigned CoordW = 16;
  localparam int unsigned CodeW  = 33;
  localparam int unsigned RadW   = CodeW + 3;     // 8*code+1
  localparam int unsigned Cells  = RadW / 2;      // one root bit per cell
  localparam int unsigned RootW  = Cells;
  localparam int unsigned WW     = RootW - 1;     // triangular row index
  localparam int unsigned PtW    = WW + 1;        // signed point after unzig, room for a step
  localparam int unsigned ZzW    = PtW + 1;       // zigzag of a stepped point
  localparam int unsigned SumW   = ZzW + 1;       // a + b

  // Command codes
  localparam logic [CmdW-1:0] CmdEncode = 2'd0;
  localparam logic [CmdW-1:0] CmdDecode = 2'd1;
  localparam logic [CmdW-1:0] CmdStep   = 2'd2;

  // Step directions
  localparam logic [DirW-1:0] DirPosX = 2'd0;
  localparam logic [DirW-1:0] DirNegX = 2'd1;
  localparam logic [DirW-1:0] DirPosY = 2'd2;
  localparam logic [DirW-1:0] DirNegY = 2'd3;

  // One transaction as it travels down the pipe
  typedef struct packed {
    logic [CmdW-1:0]          cmd;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic [CodeW-1:0]         code;
    logic [DirW-1:0]          dir;
  } item_t;

  // Contents of one square root cell
  typedef struct packed {
    logic            valid;
    item_t           item;
    logic [RadW-1:0] rem;
    logic [RadW-1:0] root;
  } cell_t;

  // Zigzag value below the representable limit
  function automatic logic zz_in_range(input logic [ZzW-1:0] v);
    return 32'(v) < ZzLimit;
  endfunction

  // Natural to signed: even -> v/2, odd -> -(v+1)/2
  function automatic logic signed [PtW-1:0] unzig(input logic [WW-1:0] v);
    logic [PtW-1:0] ve;
    ve = PtW'(v);
    if (!v[0]) begin
      return signed'(ve >> 1);
    end
    return -signed'((ve + PtW'(1)) >> 1);
  endfunction

  // Signed to natural: c >= 0 -> 2c, c < 0 -> -2c-1
  function automatic logic [ZzW-1:0] zig(input logic signed [PtW-1:0] c);
    logic [ZzW-1:0] d;
    d = {c, 1'b0};
    return c[PtW-1] ? ~d : d;
  endfunction

endpackage

[rtl/core/lattice_cantor_code_step.sv]
// Top level: 18-cell square root chain followed by the pairing back end.
// done_o marks each result once it has passed the 18 root cells and the 7 back-end stages.
// Throughput: one transaction per clock; busy stays low, the pipe never stalls.
// The receiver cannot stall: each result shows for one cycle, marked by done_o.
// Reset clears only the stage valid bits; no transaction is in flight after reset.
module lattice_cantor_code_step (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [lccs_pkg::CmdW-1:0]          command_i,
  input  logic signed [lccs_pkg::CoordW-1:0] x_coord_i,
  input  logic signed [lccs_pkg::CoordW-1:0] y_coord_i,
  input  logic [lccs_pkg::CodeW-1:0]         code_in_i,
  input  logic [lccs_pkg::DirW-1:0]          direction_i,
  output logic                               done_o,
  output logic [lccs_pkg::CodeW-1:0]         code_out_o,
  output logic signed [lccs_pkg::CoordW-1:0] x_out_o,
  output logic signed [lccs_pkg::CoordW-1:0] y_out_o,
  output logic                               status_o
);

  localparam int unsigned Cells = lccs_pkg::Cells;

  lccs_pkg::cell_t chain [0:Cells];

  assign busy = 1'b0;

  // Chain head: radicand 8*code+1, root starts at zero
  assign chain[0] = '{
    valid: start,
    item:  '{cmd: command_i, x: x_coord_i, y: y_coord_i, code: code_in_i, dir: direction_i},
    rem:   {code_in_i, 3'b001},
    root:  '0
  };

  // Square root cells
  for (genvar k = 0; k < Cells; k++) begin : g_cell
    lccs_sqrt_cell #(
      .Step(k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cell_i (chain[k]),
      .cell_o (chain[k+1])
    );
  end

  // Pairing back end
  lccs_pair_unit u_pair (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cell_i     (chain[Cells]),
    .done_o     (done_o),
    .code_out_o (code_out_o),
    .x_out_o    (x_out_o),
    .y_out_o    (y_out_o),
    .status_o   (status_o)
  );

endmodule

[rtl/core/lccs_sqrt_cell.sv]
// One cell of the integer square root chain: resolves one root bit per stage.
module lccs_sqrt_cell #(
  parameter int unsigned Step = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lccs_pkg::cell_t  cell_i,
  output lccs_pkg::cell_t  cell_o
);

  localparam int unsigned RadW = lccs_pkg::RadW;
  localparam logic [RadW-1:0] Bit = RadW'(1) << (RadW - 2 - 2 * Step);

  logic            valid_q;
  lccs_pkg::item_t item_q;
  logic [RadW-1:0] rem_d, rem_q;
  logic [RadW-1:0] root_d, root_q;
  logic [RadW-1:0] trial;

  // Restoring step: subtract root+bit when it fits
  always_comb begin
    trial = cell_i.root + Bit;
    if (cell_i.rem >= trial) begin
      rem_d  = cell_i.rem - trial;
      root_d = (cell_i.root >> 1) + Bit;
    end else begin
      rem_d  = cell_i.rem;
      root_d = cell_i.root >> 1;
    end
  end

  // Valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cell_i.valid;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    item_q <= cell_i.item;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign cell_o = '{valid: valid_q, item: item_q, rem: rem_q, root: root_q};

endmodule

[rtl/core/lccs_pair_unit.sv]
// Back end: triangular split, range checks, lattice step and Cantor re-encode.
module lccs_pair_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  lccs_pkg::cell_t                    cell_i,
  output logic                               done_o,
  output logic [lccs_pkg::CodeW-1:0]         code_out_o,
  output logic signed [lccs_pkg::CoordW-1:0] x_out_o,
  output logic signed [lccs_pkg::CoordW-1:0] y_out_o,
  output logic                               status_o
);

  localparam int unsigned CodeW  = lccs_pkg::CodeW;
  localparam int unsigned CoordW = lccs_pkg::CoordW;
  localparam int unsigned RootW  = lccs_pkg::RootW;
  localparam int unsigned WW     = lccs_pkg::WW;
  localparam int unsigned PtW    = lccs_pkg::PtW;
  localparam int unsigned ZzW    = lccs_pkg::ZzW;
  localparam int unsigned SumW   = lccs_pkg::SumW;
  localparam int unsigned TriW   = 2 * WW + 1;
  localparam int unsigned ProdW  = 2 * SumW + 1;

  // Stage valid bits: A w, B t, C a/b, D points, E zig/sum, F triangle, G output
  logic [6:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[5:0], cell_i.valid};
    end
  end

  // Stage A: w = (isqrt(8c+1)-1)/2
  logic [RootW-1:0] root_m1;
  lccs_pkg::item_t  item_a_q;
  logic [WW-1:0]    w_a_q;

  assign root_m1 = cell_i.root[RootW-1:0] - RootW'(1);

  always_ff @(posedge clk_i) begin
    item_a_q <= cell_i.item;
    w_a_q    <= root_m1[RootW-1:1];
  end

  // Stage B: t = w(w+1)/2
  logic [TriW-1:0]   tri_prod;
  lccs_pkg::item_t   item_b_q;
  logic [WW-1:0]     w_b_q;
  logic [TriW-2:0]   t_b_q;

  assign tri_prod = TriW'(w_a_q) * (TriW'(w_a_q) + TriW'(1));

  always_ff @(posedge clk_i) begin
    item_b_q <= item_a_q;
    w_b_q    <= w_a_q;
    t_b_q    <= tri_prod[TriW-1:1];
  end

  // Stage C: b = code - t, a = w - b
  logic [CodeW-1:0] diff_c;
  logic [WW-1:0]    b_c;
  lccs_pkg::item_t  item_c_q;
  logic [WW-1:0]    a_c_q, b_c_q;

  assign diff_c = item_b_q.code - t_b_q[CodeW-1:0];
  assign b_c    = diff_c[WW-1:0];

  always_ff @(posedge clk_i) begin
    item_c_q <= item_b_q;
    a_c_q    <= w_b_q - b_c;
    b_c_q    <= b_c;
  end

  // Stage D: decoded point, range check and the moved point
  logic                  dec_ok_d;
  logic signed [PtW-1:0] px_d, py_d, nx_d, ny_d;
  lccs_pkg::item_t       item_d_q;
  logic                  dec_ok_d_q;
  logic signed [PtW-1:0] px_q, py_q, nx_q, ny_q;

  always_comb begin
    dec_ok_d = lccs_pkg::zz_in_range(ZzW'(a_c_q)) && lccs_pkg::zz_in_range(ZzW'(b_c_q));
    if (item_c_q.cmd == lccs_pkg::CmdEncode) begin
      px_d = {{(PtW-CoordW){item_c_q.x[CoordW-1]}}, item_c_q.x};
      py_d = {{(PtW-CoordW){item_c_q.y[CoordW-1]}}, item_c_q.y};
    end else begin
      px_d = lccs_pkg::unzig(a_c_q);
      py_d = lccs_pkg::unzig(b_c_q);
    end
    nx_d = px_d;
    ny_d = py_d;
    if (item_c_q.cmd == lccs_pkg::CmdStep) begin
      case (item_c_q.dir)
        lccs_pkg::DirPosX: nx_d = px_d + PtW'(1);
        lccs_pkg::DirNegX: nx_d = px_d - PtW'(1);
        lccs_pkg::DirPosY: ny_d = py_d + PtW'(1);
        lccs_pkg::DirNegY: ny_d = py_d - PtW'(1);
        default:           nx_d = px_d;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    item_d_q   <= item_c_q;
    dec_ok_d_q <= dec_ok_d;
    px_q       <= px_d;
    py_q       <= py_d;
    nx_q       <= nx_d;
    ny_q       <= ny_d;
  end

  // Stage E: zigzag of the target point and s = a + b
  logic [ZzW-1:0]        za_e, zb_e;
  lccs_pkg::item_t       item_e_q;
  logic                  dec_ok_e_q, enc_ok_e_q;
  logic signed [PtW-1:0] px_e_q, py_e_q, nx_e_q, ny_e_q;
  logic [ZzW-1:0]        zb_e_q;
  logic [SumW-1:0]       s_e_q;

  assign za_e = lccs_pkg::zig(nx_q);
  assign zb_e = lccs_pkg::zig(ny_q);

  always_ff @(posedge clk_i) begin
    item_e_q   <= item_d_q;
    dec_ok_e_q <= dec_ok_d_q;
    enc_ok_e_q <= lccs_pkg::zz_in_range(za_e) && lccs_pkg::zz_in_range(zb_e);
    px_e_q     <= px_q;
    py_e_q     <= py_q;
    nx_e_q     <= nx_q;
    ny_e_q     <= ny_q;
    zb_e_q     <= zb_e;
    s_e_q      <= SumW'(za_e) + SumW'(zb_e);
  end

  // Stage F: s(s+1)/2, kept modulo the code width
  logic [ProdW-1:0]      s_prod;
  lccs_pkg::item_t       item_f_q;
  logic                  dec_ok_f_q, enc_ok_f_q;
  logic signed [PtW-1:0] px_f_q, py_f_q, nx_f_q, ny_f_q;
  logic [ZzW-1:0]        zb_f_q;
  logic [CodeW-1:0]      tri_f_q;

  assign s_prod = ProdW'(s_e_q) * (ProdW'(s_e_q) + ProdW'(1));

  always_ff @(posedge clk_i) begin
    item_f_q   <= item_e_q;
    dec_ok_f_q <= dec_ok_e_q;
    enc_ok_f_q <= enc_ok_e_q;
    px_f_q     <= px_e_q;
    py_f_q     <= py_e_q;
    nx_f_q     <= nx_e_q;
    ny_f_q     <= ny_e_q;
    zb_f_q     <= zb_e_q;
    tri_f_q    <= s_prod[CodeW:1];
  end

  // Stage G: pick the result per command
  logic [CodeW-1:0]      enc_code;
  logic [CodeW-1:0]      code_d, code_q;
  logic signed [PtW-1:0] ox_d, oy_d;
  logic [CoordW-1:0]     x_q, y_q;
  logic                  status_d, status_q;

  assign enc_code = tri_f_q + CodeW'(zb_f_q);

  always_comb begin
    code_d   = item_f_q.code;
    ox_d     = '0;
    oy_d     = '0;
    status_d = 1'b1;
    case (item_f_q.cmd)
      lccs_pkg::CmdEncode: begin
        if (enc_ok_f_q) begin
          code_d   = enc_code;
          ox_d     = nx_f_q;
          oy_d     = ny_f_q;
          status_d = 1'b0;
        end else begin
          code_d = '0;
        end
      end
      lccs_pkg::CmdDecode: begin
        if (dec_ok_f_q) begin
          ox_d     = px_f_q;
          oy_d     = py_f_q;
          status_d = 1'b0;
        end
      end
      lccs_pkg::CmdStep: begin
        if (dec_ok_f_q && enc_ok_f_q) begin
          code_d   = enc_code;
          ox_d     = nx_f_q;
          oy_d     = ny_f_q;
          status_d = 1'b0;
        end else if (dec_ok_f_q) begin
          ox_d = px_f_q;
          oy_d = py_f_q;
        end
      end
      default: begin
        code_d = item_f_q.code;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    code_q   <= code_d;
    x_q      <= ox_d[CoordW-1:0];
    y_q      <= oy_d[CoordW-1:0];
    status_q <= status_d;
  end

  assign done_o     = vld_q[6];
  assign code_out_o = code_q;
  assign x_out_o    = signed'(x_q);
  assign y_out_o    = signed'(y_q);
  assign status_o   = status_q;

endmodule

[tb/tb_lattice_cantor_code_step.sv]
// Testbench for lattice_cantor_code_step: directed table, then random commands checked by a predictor.
module tb_lattice_cantor_code_step;

  localparam int unsigned CmdW      = lccs_pkg::CmdW;
  localparam int unsigned DirW      = lccs_pkg::DirW;
  localparam int unsigned CoordW    = lccs_pkg::CoordW;
  localparam int unsigned CodeW     = lccs_pkg::CodeW;
  localparam int unsigned CoordBits = lccs_pkg::CoordBits;

  // Command three has no meaning; the unit must flag it
  localparam logic [CmdW-1:0] CmdUnused   = 2'd3;
  localparam longint          ZzBound     = longint'(1) << CoordBits;
  localparam int              RandomItems = 1050;
  localparam int              CycleLimit  = 200000;
  localparam int              DrainCycles = 40;

  // One result as it leaves the unit
  typedef struct packed {
    logic [CodeW-1:0]         code;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic                     status;
  } lattice_result_t;

  // Row of the directed table; typed rows carry their own expected result
  typedef struct {
    lccs_pkg::item_t stim;
    bit              typed;
    lattice_result_t want;
  } stim_row_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start;
  logic                     busy;
  logic [CmdW-1:0]          command_i;
  logic signed [CoordW-1:0] x_coord_i;
  logic signed [CoordW-1:0] y_coord_i;
  logic [CodeW-1:0]         code_in_i;
  logic [DirW-1:0]          direction_i;
  logic                     done_o;
  logic [CodeW-1:0]         code_out_o;
  logic signed [CoordW-1:0] x_out_o;
  logic signed [CoordW-1:0] y_out_o;
  logic                     status_o;

  lattice_result_t pending_results[$];
  stim_row_t       directed_rows[$];
  int              fail_count;
  int              cycle_count;

  lattice_cantor_code_step u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .command_i   (command_i),
    .x_coord_i   (x_coord_i),
    .y_coord_i   (y_coord_i),
    .code_in_i   (code_in_i),
    .direction_i (direction_i),
    .done_o      (done_o),
    .code_out_o  (code_out_o),
    .x_out_o     (x_out_o),
    .y_out_o     (y_out_o),
    .status_o    (status_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Zigzag map of a signed coordinate onto the naturals
  function automatic longint zz_of(input longint c);
    return (c >= 0) ? 2 * c : -2 * c - 1;
  endfunction

  function automatic longint from_zz(input longint v);
    return v[0] ? -((v + 1) >>> 1) : (v >>> 1);
  endfunction

  // Largest r with r*r <= n, built one bit at a time
  function automatic longint exact_root(input longint n);
    longint r;
    longint cand;
    r = 0;
    for (int k = 18; k >= 0; k--) begin
      cand = r | (longint'(1) << k);
      if (cand * cand <= n) r = cand;
    end
    return r;
  endfunction

  // Cantor index of a point whose zigzag values are in range
  function automatic logic [CodeW-1:0] lattice_code_of(input longint x, input longint y);
    longint a;
    longint b;
    longint s;
    a = zz_of(x);
    b = zz_of(y);
    s = a + b;
    return CodeW'(s * (s + 1) / 2 + b);
  endfunction

  // Inverse pairing; returns 0 when either coordinate is not representable
  function automatic bit split_code(input logic [CodeW-1:0] code, output longint px,
                                    output longint py);
    longint c;
    longint w;
    longint a;
    longint b;
    c  = longint'(code);
    w  = (exact_root(8 * c + 1) - 1) / 2;
    b  = c - (w * w + w) / 2;
    a  = w - b;
    px = from_zz(a);
    py = from_zz(b);
    return (a < ZzBound) && (b < ZzBound);
  endfunction

  // Expected result of one accepted transaction
  function automatic lattice_result_t predict_cantor_result(input lccs_pkg::item_t it);
    lattice_result_t res;
    longint px;
    longint py;
    longint nx;
    longint ny;
    res = '{code: it.code, x: '0, y: '0, status: 1'b1};
    case (it.cmd)
      lccs_pkg::CmdEncode: begin
        res = '{code: lattice_code_of(it.x, it.y), x: it.x, y: it.y, status: 1'b0};
      end
      lccs_pkg::CmdDecode: begin
        if (split_code(it.code, px, py)) begin
          res.x      = CoordW'(px);
          res.y      = CoordW'(py);
          res.status = 1'b0;
        end
      end
      lccs_pkg::CmdStep: begin
        if (split_code(it.code, px, py)) begin
          nx = px;
          ny = py;
          case (it.dir)
            lccs_pkg::DirPosX: nx = px + 1;
            lccs_pkg::DirNegX: nx = px - 1;
            lccs_pkg::DirPosY: ny = py + 1;
            default:           ny = py - 1;
          endcase
          // Leaving the range keeps the index and reports the unmoved point
          if (zz_of(nx) < ZzBound && zz_of(ny) < ZzBound) begin
            res = '{code: lattice_code_of(nx, ny), x: CoordW'(nx), y: CoordW'(ny),
                    status: 1'b0};
          end else begin
            res.x = CoordW'(px);
            res.y = CoordW'(py);
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic logic signed [CoordW-1:0] pick_coord();
    case ($urandom_range(0, 7))
      0:       return -16'sd32768;
      1:       return 16'sd32767;
      2:       return signed'(16'($urandom_range(0, 4)) - 16'd2);
      default: return signed'(16'($urandom));
    endcase
  endfunction

  function automatic logic [CodeW-1:0] any_code();
    return {1'($urandom), 32'($urandom)};
  endfunction

  // Random command; mostly indexes of real points so decode and step go deep
  function automatic lccs_pkg::item_t random_item();
    lccs_pkg::item_t it;
    int              pick;
    it.cmd  = lccs_pkg::CmdEncode;
    it.x    = signed'(16'($urandom));
    it.y    = signed'(16'($urandom));
    it.code = any_code();
    it.dir  = DirW'($urandom);
    pick    = $urandom_range(0, 99);
    if (pick < 25) begin
      it.x = pick_coord();
      it.y = pick_coord();
    end else if (pick < 45) begin
      it.cmd = lccs_pkg::CmdDecode;
      if ($urandom_range(0, 9) < 7) it.code = lattice_code_of(pick_coord(), pick_coord());
    end else if (pick < 95) begin
      it.cmd = lccs_pkg::CmdStep;
      if ($urandom_range(0, 9) != 0) it.code = lattice_code_of(pick_coord(), pick_coord());
    end else begin
      it.cmd = CmdUnused;
    end
    return it;
  endfunction

  task automatic add_row(input logic [CmdW-1:0] cmd, input longint x, input longint y,
                         input logic [CodeW-1:0] code, input logic [DirW-1:0] dir,
                         input bit typed, input lattice_result_t want);
    stim_row_t row;
    row.stim  = '{cmd: cmd, x: CoordW'(x), y: CoordW'(y), code: code, dir: dir};
    row.typed = typed;
    row.want  = want;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // Drive one transaction after an idle gap and record what it must produce
  task automatic send_item(input lccs_pkg::item_t it, input int gap, input bit typed,
                           input lattice_result_t want);
    repeat (gap) begin
      @(negedge clk_i);
      start = 1'b0;
    end
    @(negedge clk_i);
    start       = 1'b1;
    command_i   = it.cmd;
    x_coord_i   = it.x;
    y_coord_i   = it.y;
    code_in_i   = it.code;
    direction_i = it.dir;
    do @(posedge clk_i); while (busy);
    pending_results.insert(pending_results.size(),
                           typed ? want : predict_cantor_result(it));
  endtask

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("ERROR: %s", msg);
  endtask

  // Result checker
  always @(posedge clk_i) begin
    lattice_result_t got;
    lattice_result_t exp_res;
    if (rst_ni && done_o) begin
      got = '{code: code_out_o, x: x_out_o, y: y_out_o, status: status_o};
      if (pending_results.size() == 0) begin
        note_failure($sformatf("result with none pending: code %0d x %0d y %0d status %0b",
                               got.code, got.x, got.y, got.status));
      end else begin
        exp_res = pending_results.pop_front();
        if (got.code !== exp_res.code || got.x !== exp_res.x || got.y !== exp_res.y ||
            got.status !== exp_res.status) begin
          note_failure($sformatf(
            "expected code %0d x %0d y %0d status %0b, got code %0d x %0d y %0d status %0b",
            exp_res.code, exp_res.x, exp_res.y, exp_res.status,
            got.code, got.x, got.y, got.status));
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Stimulus
  initial begin
    lattice_result_t none;
    int              gap;
    bit              burst;
    none        = '0;
    fail_count  = 0;
    cycle_count = 0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    command_i   = lccs_pkg::CmdEncode;
    x_coord_i   = '0;
    y_coord_i   = '0;
    code_in_i   = '0;
    direction_i = lccs_pkg::DirPosX;

    // Origin, extremes, the unused command and the out-of-range cases
    add_row(lccs_pkg::CmdEncode, 0, 0, '0, lccs_pkg::DirPosX, 1'b1,
            '{code: '0, x: '0, y: '0, status: 1'b0});
    add_row(lccs_pkg::CmdDecode, 0, 0, '0, lccs_pkg::DirPosX, 1'b1,
            '{code: '0, x: '0, y: '0, status: 1'b0});
    add_row(CmdUnused, -1, -1, 33'h1_5555_5555, lccs_pkg::DirNegY, 1'b1,
            '{code: 33'h1_5555_5555, x: '0, y: '0, status: 1'b1});
    add_row(lccs_pkg::CmdDecode, 0, 0, '1, lccs_pkg::DirPosX, 1'b1,
            '{code: '1, x: '0, y: '0, status: 1'b1});
    add_row(lccs_pkg::CmdEncode, -32768, -32768, '0, lccs_pkg::DirPosX, 1'b1,
            '{code: 33'd8589803520, x: -16'sd32768, y: -16'sd32768, status: 1'b0});
    add_row(lccs_pkg::CmdEncode, 32767, 32767, '1, lccs_pkg::DirNegY, 1'b0, none);
    add_row(lccs_pkg::CmdEncode, 32767, -32768, '0, lccs_pkg::DirPosX, 1'b0, none);
    add_row(lccs_pkg::CmdEncode, -32768, 32767, '0, lccs_pkg::DirPosX, 1'b0, none);
    add_row(lccs_pkg::CmdEncode, -1, 1, '0, lccs_pkg::DirPosX, 1'b0, none);
    add_row(lccs_pkg::CmdDecode, 0, 0, 33'd8589803520, lccs_pkg::DirPosX, 1'b0, none);
    add_row(lccs_pkg::CmdDecode, 0, 0, 33'd8589803521, lccs_pkg::DirPosX, 1'b0, none);
    add_row(lccs_pkg::CmdDecode, 0, 0, 33'd8589869520, lccs_pkg::DirPosX, 1'b0, none);
    // Steps off each edge of the range, ordinary steps, and a step from a bad index
    add_row(lccs_pkg::CmdStep, 0, 0, lattice_code_of(32767, 5), lccs_pkg::DirPosX,
            1'b0, none);
    add_row(lccs_pkg::CmdStep, 0, 0, lattice_code_of(-32768, 5), lccs_pkg::DirNegX,
            1'b0, none);
    add_row(lccs_pkg::CmdStep, 0, 0, lattice_code_of(5, 32767), lccs_pkg::DirPosY,
            1'b0, none);
    add_row(lccs_pkg::CmdStep, 0, 0, lattice_code_of(5, -32768), lccs_pkg::DirNegY,
            1'b0, none);
    add_row(lccs_pkg::CmdStep, 0, 0, '0, lccs_pkg::DirPosX, 1'b0, none);
    add_row(lccs_pkg::CmdStep, 0, 0, '0, lccs_pkg::DirNegX, 1'b0, none);
    add_row(lccs_pkg::CmdStep, 0, 0, '0, lccs_pkg::DirPosY, 1'b0, none);
    add_row(lccs_pkg::CmdStep, 0, 0, '0, lccs_pkg::DirNegY, 1'b0, none);
    add_row(lccs_pkg::CmdStep, 0, 0, lattice_code_of(-1, -1), lccs_pkg::DirPosX,
            1'b0, none);
    add_row(lccs_pkg::CmdStep, 0, 0, lattice_code_of(32767, -32768), lccs_pkg::DirNegX,
            1'b0, none);
    add_row(lccs_pkg::CmdStep, 0, 0, '1, lccs_pkg::DirPosX, 1'b0, none);

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].stim, $urandom_range(0, 11), directed_rows[i].typed,
                directed_rows[i].want);
    end

    // Random part; some stretches run back to back
    burst = 1'b0;
    for (int n = 0; n < RandomItems; n++) begin
      if (n % 64 == 0) burst = ($urandom_range(0, 2) == 0);
      gap = burst ? 0 : $urandom_range(0, 11);
      send_item(random_item(), gap, 1'b0, none);
    end
    @(negedge clk_i);
    start = 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (pending_results.size() != 0) note_failure("results still pending at end of run");

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/lccs_pkg.sv
rtl/core/lccs_sqrt_cell.sv
rtl/core/lccs_pair_unit.sv
rtl/core/lattice_cantor_code_step.sv
tb/tb_lattice_cantor_code_step.sv
